/* src/ffba_pkg.sv */
package ffba_pkg;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NOFIT   = 2'd1;
  localparam logic [1:0] STATUS_BADADDR = 2'd2;

  localparam int unsigned OFFSET_W = 10;
  localparam int unsigned MIN_SPLIT_BYTES = 16;

  typedef struct packed {
    logic wr_init;   // write the head entry after reset
    logic load_req;  // capture an input transfer
    logic rd_next;   // read the successor of the entry under test
    logic wr_hit;    // update the matching entry, latch result
    logic res_fail;  // latch a failure result
    logic wr_split;  // write the split-off entry
    logic push_out;  // move the result into the output register
  } ffba_cmd_t;

  typedef struct packed {
    logic hit;       // entry under test fits (alloc) or matches (free)
    logic last;      // entry under test ends the chain
    logic split;     // hit entry will be split
    logic out_free;  // output register can take a result this cycle
  } ffba_sts_t;

endpackage

/* src/ffba_ctrl.sv */
module ffba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffba_pkg::ffba_sts_t sts,
  output ffba_pkg::ffba_cmd_t cmd
);
  import ffba_pkg::*;

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CHECK = 5'b00100,
    S_SPLIT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        cmd.wr_init = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.hit) begin
          cmd.wr_hit = 1'b1;
          state_nxt  = sts.split ? S_SPLIT : S_DONE;
        end else if (sts.last) begin
          cmd.res_fail = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_SPLIT: begin
        cmd.wr_split = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

/* src/ffba_datapath.sv */
module ffba_datapath #(
  parameter int unsigned HEAP_BYTES  = 1024,
  parameter int unsigned ALIGN_BYTES = 16,
  parameter int unsigned MAX_BLOCKS  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ffba_pkg::ffba_cmd_t cmd,
  output ffba_pkg::ffba_sts_t sts,
  input  logic                in_func,
  input  logic [9:0]          in_request_bytes,
  input  logic [9:0]          in_free_offset,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [9:0]          out_data_offset,
  output logic [1:0]          out_status
);
  import ffba_pkg::*;

  localparam int unsigned IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned SW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned HW  = $clog2(HEAP_BYTES + 1);
  localparam int unsigned AW  = (HW > OFFSET_W + 1) ? HW : OFFSET_W + 1;
  localparam int unsigned HDR = ((16 + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;

  localparam logic [AW-1:0] HDR_A       = AW'(HDR);
  localparam logic [AW-1:0] SPLIT_MIN   = AW'(HDR + MIN_SPLIT_BYTES);
  localparam logic [AW-1:0] HEAD_SIZE   = AW'(HEAP_BYTES - HDR);
  localparam logic [AW-1:0] OFFSET_MAX  = AW'((1 << OFFSET_W) - 1);
  localparam logic [AW-1:0] ALIGN_A     = AW'(ALIGN_BYTES);
  localparam logic [AW-1:0] ALIGN_M1    = AW'(ALIGN_BYTES - 1);
  localparam logic [SW-1:0] SLOTS       = SW'(MAX_BLOCKS);

  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] size;
    logic          busy;
    logic [IW-1:0] link;
  } entry_t;

  entry_t mem [MAX_BLOCKS];

  entry_t        rd_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] raddr;

  logic          func_r;
  logic [AW-1:0] need_r;
  logic [9:0]    off_r;
  logic [SW-1:0] spare_r, spare_nxt;
  entry_t        split_r;
  logic [9:0]    res_offset_r;
  logic [1:0]    res_status_r;

  logic          out_valid_r, out_valid_nxt;
  logic [9:0]    out_data_offset_r;
  logic [1:0]    out_status_r;

  logic [AW-1:0] req_sum;
  logic [AW-1:0] need_in;
  logic [AW-1:0] base;
  logic [AW-1:0] rem;
  logic          fit, match, hit, do_split;

  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  entry_t        hit_entry;
  entry_t        tail_entry;

  assign req_sum = {{(AW - OFFSET_W){1'b0}}, in_request_bytes} + ALIGN_M1;
  assign need_in = AW'((req_sum / ALIGN_A) * ALIGN_A);

  assign base     = rd_r.start + HDR_A;
  assign rem      = rd_r.size - need_r;
  assign fit      = !rd_r.busy && (rd_r.size >= need_r);
  assign match    = (base[9:0] == off_r) && (base <= OFFSET_MAX);
  assign hit      = (func_r == FUNC_ALLOC) ? fit : match;
  assign do_split = (func_r == FUNC_ALLOC) && (rem >= SPLIT_MIN) && (spare_r < SLOTS);

  assign sts.hit      = hit;
  assign sts.last     = (rd_r.link == '0);
  assign sts.split    = do_split;
  assign sts.out_free = !out_valid_r || !out_stall;

  // head entry is always read outside of a walk, so it is already in rd_r when the first test starts
  assign raddr = cmd.rd_next ? rd_r.link : '0;

  always_ff @(posedge clk) begin
    rd_r  <= mem[raddr];
    idx_r <= raddr;
  end

  always_comb begin
    hit_entry = rd_r;
    if (func_r == FUNC_ALLOC) begin
      hit_entry.busy = 1'b1;
      if (do_split) begin
        hit_entry.size = need_r;
        hit_entry.link = spare_r[IW-1:0];
      end
    end else begin
      hit_entry.busy = 1'b0;
    end

    tail_entry.start = base + need_r;
    tail_entry.size  = rem - HDR_A;
    tail_entry.busy  = 1'b0;
    tail_entry.link  = rd_r.link;
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.wr_init) begin
      we         = 1'b1;
      wdata.size = HEAD_SIZE;
    end else if (cmd.wr_hit) begin
      we    = 1'b1;
      waddr = idx_r;
      wdata = hit_entry;
    end else if (cmd.wr_split) begin
      we    = 1'b1;
      waddr = spare_r[IW-1:0];
      wdata = split_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign spare_nxt = cmd.wr_split ? spare_r + SW'(1) : spare_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spare_r <= SW'(1);
    end else begin
      spare_r <= spare_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      func_r <= in_func;
      need_r <= need_in;
      off_r  <= in_free_offset;
    end
    if (cmd.wr_hit) begin
      split_r      <= tail_entry;
      res_offset_r <= (func_r == FUNC_ALLOC) ? base[9:0] : 10'd0;
      res_status_r <= STATUS_OK;
    end else if (cmd.res_fail) begin
      res_offset_r <= 10'd0;
      res_status_r <= (func_r == FUNC_ALLOC) ? STATUS_NOFIT : STATUS_BADADDR;
    end
    if (cmd.push_out) begin
      out_data_offset_r <= res_offset_r;
      out_status_r      <= res_status_r;
    end
  end

  assign out_valid_nxt = cmd.push_out ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_offset = out_data_offset_r;
  assign out_status      = out_status_r;

endmodule

/* src/first_fit_block_allocator_core.sv */
// channel  direction  ports                                        transfer
// in       input      in_func, in_request_bytes, in_free_offset    in_valid & !in_stall
// out      output     out_data_offset, out_status                  out_valid & !out_stall
//
// An item walks n block entries (1..MAX_BLOCKS) in S_CHECK, then passes through S_SPLIT
// when an allocate splits its block, and S_DONE, where its result moves to the output
// register; only then is the next input transfer taken.
// The walk tests one entry per cycle through the single read port of the block table.
// After reset the head entry is written in S_INIT; in_stall is high meanwhile.
// The next item is taken while a result still waits under out_stall.
module first_fit_block_allocator_core #(
  parameter int unsigned HEAP_BYTES  = 1024,
  parameter int unsigned ALIGN_BYTES = 16,
  parameter int unsigned MAX_BLOCKS  = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_func,
  input  logic [9:0] in_request_bytes,
  input  logic [9:0] in_free_offset,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [9:0] out_data_offset,
  output logic [1:0] out_status
);
  import ffba_pkg::*;

  ffba_cmd_t cmd;
  ffba_sts_t sts;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffba_datapath #(
    .HEAP_BYTES  (HEAP_BYTES),
    .ALIGN_BYTES (ALIGN_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_func),
    .in_request_bytes (in_request_bytes),
    .in_free_offset   (in_free_offset),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data_offset  (out_data_offset),
    .out_status       (out_status)
  );

endmodule
